@@ sv/two_digit_hex_dec_id_parser_top_macros.svh @@
// Assertion macros for the two-digit hex/decimal ID parser.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef TWO_DIGIT_HEX_DEC_ID_PARSER_TOP_MACROS_SVH
`define TWO_DIGIT_HEX_DEC_ID_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define TDHD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define TDHD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/tdhd_pkg.sv @@
// Shared types and constants for the two-digit hex/decimal ID parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package tdhd_pkg;

	// Shortest token that draws a too-many-digits report (5..15)
	localparam int MAX_LEN = 5;
	localparam logic [4:0] MAX_LEN_C = 5'(MAX_LEN);
	localparam logic [4:0] BLANK_LIM = 5'(2 * MAX_LEN);

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW = $clog2(QDEPTH);

	// Preset format register codes
	localparam logic [1:0] PRE_AUTO = 2'd0;
	localparam logic [1:0] PRE_HEX  = 2'd1;
	localparam logic [1:0] PRE_DEC  = 2'd2;

	typedef enum logic [3:0] {
		ST_GOOD        = 4'd0,
		ST_BLANK_ONLY  = 4'd1,
		ST_BAD_FIRST   = 4'd2,
		ST_BAD_SECOND  = 4'd3,
		ST_BAD_DIG1    = 4'd4,
		ST_BAD_DIG2    = 4'd5,
		ST_TOO_MANY    = 4'd6,
		ST_BAD_SUFFIX  = 4'd7,
		ST_PRE_AND_SUF = 4'd8,
		ST_HEX_DEC1    = 4'd9,
		ST_HEX_DEC2    = 4'd10,
		ST_NO_DIGITS   = 4'd11
	} stat_t;

	// Classified character as passed from front to back
	typedef struct packed {
		logic       term;   // zero byte
		logic       blank;  // space or tab
		logic       zero;   // '0'
		logic       isdig;  // '0'..'9'
		logic       isx;    // any hex digit
		logic       xch;    // x or X
		logic       hch;    // h or H
		logic       dch;    // d or D
		logic [3:0] nib;    // hex digit value when isx
	} class_t;

endpackage

`default_nettype wire

@@ sv/tdhd_front.sv @@
// Front end: accepts characters, classifies them and registers the class.
// Depends on tdhd_pkg.
`default_nettype none

module tdhd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [7:0]      s_tdata,   // [7:0] character
	output logic                 push,
	output tdhd_pkg::class_t     push_cls,
	input  wire logic            q_full
);
	import tdhd_pkg::*;

	logic   vld_s1;
	class_t cls_s1;

	function automatic class_t classify(input logic [7:0] c);
		class_t r;
		r.term  = (c == 8'h00);
		r.blank = (c == 8'h20) || (c == 8'h09);
		r.zero  = (c == 8'h30);
		r.isdig = (c >= 8'h30) && (c <= 8'h39);
		r.xch   = (c == 8'h78) || (c == 8'h58);
		r.hch   = (c == 8'h68) || (c == 8'h48);
		r.dch   = (c == 8'h64) || (c == 8'h44);
		r.isx   = 1'b1;
		r.nib   = 4'd0;
		if (r.isdig) begin
			r.nib = 4'(c - 8'h30);
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			r.nib = 4'(c - 8'h57);
		end else if ((c >= 8'h41) && (c <= 8'h46)) begin
			r.nib = 4'(c - 8'h37);
		end else begin
			r.isx = 1'b0;
		end
		return r;
	endfunction

	// Move the stage into the queue whenever there is room
	assign push     = vld_s1 && !q_full;
	assign push_cls = cls_s1;
	assign s_tready = !vld_s1 || !q_full;

	// Hold the classified character until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cls_s1 <= classify(s_tdata);
		end
	end

endmodule

`default_nettype wire

@@ sv/tdhd_queue.sv @@
// Short queue of classified characters between front and back.
// Depends on tdhd_pkg.
`default_nettype none

module tdhd_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire tdhd_pkg::class_t push_cls,
	output logic                  full,
	input  wire logic             pop,
	output logic                  q_valid,
	output tdhd_pkg::class_t      head
);
	import tdhd_pkg::*;

	class_t           mem_q [QDEPTH];
	logic [QAW-1:0]   wptr_q;
	logic [QAW-1:0]   rptr_q;
	logic [QAW:0]     cnt_q;

	assign full    = (cnt_q == (QAW+1)'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign head    = mem_q[rptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QAW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QAW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cls;
		end
	end

endmodule

`default_nettype wire

@@ sv/tdhd_back.sv @@
// Back end: parser state machine and result register.
// Depends on tdhd_pkg and the assertion macro header.
`default_nettype none
`include "two_digit_hex_dec_id_parser_top_macros.svh"

module tdhd_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [1:0]       preset_format,
	input  wire logic             q_valid,
	input  wire tdhd_pkg::class_t head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [15:0]           m_tdata
);
	import tdhd_pkg::*;

	typedef enum logic [3:0] {
		S_INIT    = 4'd0,
		S_ZERO1   = 4'd1,
		S_PREFIX  = 4'd2,
		S_IND1    = 4'd3,
		S_IND2    = 4'd4,
		S_DEC1    = 4'd5,
		S_DEC2    = 4'd6,
		S_HEX1    = 4'd7,
		S_HEX2    = 4'd8,
		S_ZERO2   = 4'd9,
		S_DONE    = 4'd10,
		S_PHEX    = 4'd11,
		S_PDEC    = 4'd12,
		S_PDEC_Z1 = 4'd13,
		S_PDEC_Z2 = 4'd14
	} state_t;

	state_t      state_q, st;
	logic        skip_q, sk;
	logic [4:0]  cnt_q, cnt;
	logic [4:0]  fn_q, fn;
	logic [4:0]  sn_q, sn;
	logic        hex_q, hx;
	logic        dec_q, dc;
	logic        pre_q, pf;
	stat_t       err_q, er;
	logic        halt_q, hl;
	logic        flt;
	stat_t       fcode;
	logic [4:0]  nibx;

	stat_t       res_stat;
	logic [7:0]  res_val;
	logic        res_hex, res_dec;
	logic [3:0]  msd, lsd;

	logic        out_vld_q;
	stat_t       out_stat_q;
	logic [7:0]  out_val_q;
	logic        out_hex_q, out_dec_q;
	logic        take_term;

	// Take a character whenever the result register is free or draining
	assign pop       = q_valid && (!out_vld_q || m_tready);
	assign take_term = pop && head.term;
	assign nibx      = {1'b0, head.nib};

	// Next state for a non-terminator character
	always_comb begin
		st = state_q; sk = skip_q; cnt = cnt_q; fn = fn_q; sn = sn_q;
		hx = hex_q; dc = dec_q; pf = pre_q; er = err_q; hl = halt_q;
		flt = 1'b0; fcode = ST_TOO_MANY;
		if (sk && (cnt <= BLANK_LIM) && head.blank) begin
			cnt = cnt + 1'b1;
		end else begin
			if (sk) begin
				sk  = 1'b0;
				cnt = '0;
				hx  = (preset_format == PRE_HEX);
				dc  = (preset_format == PRE_DEC);
				st  = hx ? S_PHEX : (dc ? S_PDEC : S_INIT);
			end
			if (!(hl || (cnt > MAX_LEN_C))) begin
				unique case (st)
					S_INIT: begin
						if (head.zero) begin
							fn = '0; st = S_ZERO1;
						end else if (head.isx) begin
							if (head.isdig) st = S_IND1;
							else begin hx = 1'b1; st = S_HEX1; end
							fn = nibx;
						end else if (head.xch) begin
							hx = 1'b1; pf = 1'b1; st = S_PREFIX;
						end else begin
							flt = 1'b1; fcode = ST_BAD_FIRST;
						end
					end
					S_ZERO1: begin
						if (head.zero) begin
							sn = '0; st = S_ZERO2;
						end else if (head.xch) begin
							hx = 1'b1; pf = 1'b1; st = S_PREFIX;
						end else if (head.isx) begin
							if (!head.isdig) begin hx = 1'b1; st = S_HEX2; end
							else st = S_IND2;
							fn = nibx;
						end else if (head.hch) begin
							hx = 1'b1; st = S_DONE;
						end else begin
							flt = 1'b1; fcode = ST_BAD_DIG2;
						end
					end
					S_PREFIX: begin
						if (head.isx) begin
							fn = nibx; st = S_HEX1;
						end else begin
							flt = 1'b1; fcode = ST_BAD_DIG1;
						end
					end
					S_IND1: begin
						if (head.isx) begin
							if (head.isdig) st = S_IND2;
							else begin hx = 1'b1; st = S_HEX2; end
							sn = nibx;
						end else if (head.xch || head.hch) begin
							hx = 1'b1; st = S_DONE;
						end else begin
							flt = 1'b1; fcode = ST_BAD_DIG2;
						end
					end
					S_IND2: begin
						if (head.xch || head.hch) begin
							hx = 1'b1; st = S_DONE;
						end else if (head.dch) begin
							dc = 1'b1; st = S_DONE;
						end else begin
							flt = 1'b1; fcode = ST_TOO_MANY;
						end
					end
					S_DEC1: begin
						if (head.isdig) begin
							sn = nibx; st = S_DEC2;
						end else begin
							flt = 1'b1; fcode = ST_BAD_DIG2;
						end
					end
					S_DEC2, S_PDEC_Z2: begin
						if (head.dch) st = S_DONE;
						else begin flt = 1'b1; fcode = ST_BAD_SUFFIX; end
					end
					S_HEX1: begin
						if (head.isx) begin
							sn = nibx; st = S_HEX2;
						end else if (head.xch || head.hch) begin
							if (pf) begin flt = 1'b1; fcode = ST_PRE_AND_SUF; end
							else begin hx = 1'b1; st = S_DONE; end
						end else begin
							flt = 1'b1; fcode = ST_BAD_DIG2;
						end
					end
					S_HEX2: begin
						if (head.xch || head.hch) st = S_DONE;
						else begin flt = 1'b1; fcode = ST_BAD_SUFFIX; end
					end
					S_ZERO2: begin
						if (!dc && (head.xch || head.hch)) begin
							hx = 1'b1; st = S_DONE;
						end else if (!hx && head.dch) begin
							dc = 1'b1; st = S_DONE;
						end else begin
							flt = 1'b1; fcode = ST_TOO_MANY;
						end
					end
					S_PHEX: begin
						if (head.xch) begin
							pf = 1'b1; st = S_PREFIX;
						end else if (head.zero) begin
							fn = '0; st = S_ZERO1;
						end else if (head.isx) begin
							fn = nibx; st = S_HEX1;
						end else begin
							flt = 1'b1; fcode = ST_BAD_FIRST;
						end
					end
					S_PDEC: begin
						if (head.xch || (head.isx && !head.isdig)) begin
							flt = 1'b1; fcode = ST_HEX_DEC1;
						end else if (head.zero) begin
							fn = '0; st = S_PDEC_Z1;
						end else if (head.isdig) begin
							fn = nibx; st = S_DEC1;
						end else begin
							flt = 1'b1; fcode = ST_BAD_FIRST;
						end
					end
					S_PDEC_Z1: begin
						if (head.xch || (head.isx && !head.isdig)) begin
							flt = 1'b1; fcode = ST_HEX_DEC2;
						end else if (head.zero) begin
							st = S_PDEC_Z2;
						end else if (head.isdig) begin
							fn = nibx; st = S_DEC2;
						end else begin
							flt = 1'b1; fcode = ST_BAD_SECOND;
						end
					end
					default: begin
						// done state and the unused code: any further character
						flt = 1'b1; fcode = ST_TOO_MANY;
					end
				endcase
				if (flt) begin
					er = fcode; hl = 1'b1;
				end
				if (!hl) cnt = cnt + 1'b1;
			end
		end
	end

	// Result for a terminator
	always_comb begin
		msd = '0; lsd = '0; res_val = '0;
		res_hex = hex_q; res_dec = dec_q;
		if (skip_q) begin
			res_stat = ST_BLANK_ONLY;
			res_hex  = (preset_format == PRE_HEX);
			res_dec  = (preset_format == PRE_DEC);
		end else if (cnt_q >= MAX_LEN_C) begin
			res_stat = ST_TOO_MANY;
		end else if (halt_q) begin
			res_stat = err_q;
		end else if ((hex_q || dec_q) && fn_q[4] && sn_q[4]) begin
			res_stat = ST_NO_DIGITS;
		end else begin
			res_stat = ST_GOOD;
			if (sn_q[4]) begin
				lsd = fn_q[4] ? 4'd0 : fn_q[3:0];
			end else begin
				msd = fn_q[4] ? 4'd0 : fn_q[3:0];
				lsd = sn_q[3:0];
			end
			if (hex_q || !dec_q) res_val = {msd, lsd};
			else res_val = {1'b0, msd, 3'b000} + {3'b000, msd, 1'b0} + {4'b0000, lsd};
		end
	end

	// Hold parser state; clear it at each terminator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT; skip_q <= 1'b1; cnt_q <= '0;
			fn_q <= 5'h10; sn_q <= 5'h10; hex_q <= 1'b0; dec_q <= 1'b0;
			pre_q <= 1'b0; err_q <= ST_GOOD; halt_q <= 1'b0;
		end else if (take_term) begin
			state_q <= S_INIT; skip_q <= 1'b1; cnt_q <= '0;
			fn_q <= 5'h10; sn_q <= 5'h10; hex_q <= 1'b0; dec_q <= 1'b0;
			pre_q <= 1'b0; err_q <= ST_GOOD; halt_q <= 1'b0;
		end else if (pop) begin
			state_q <= st; skip_q <= sk; cnt_q <= cnt;
			fn_q <= fn; sn_q <= sn; hex_q <= hx; dec_q <= dc;
			pre_q <= pf; err_q <= er; halt_q <= hl;
		end
	end

	// Result register: load on terminator, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take_term) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_term) begin
			out_stat_q <= res_stat;
			out_val_q  <= res_val;
			out_hex_q  <= res_hex;
			out_dec_q  <= res_dec;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_dec_q, out_hex_q, (out_stat_q == ST_GOOD),
	                   out_val_q, out_stat_q};

	`TDHD_ASSERT_NEXT(a_term_loads, take_term, m_tvalid && (m_tdata[12] == (m_tdata[3:0] == ST_GOOD)), "terminator did not load a consistent result")
	`TDHD_ASSERT_NEXT(a_term_clears, take_term, skip_q && (cnt_q == '0) && !halt_q, "parser state not cleared after terminator")
	`TDHD_ASSERT_NOW(a_cnt_bound, !skip_q, cnt_q <= MAX_LEN_C + 5'd1, "character count ran past its limit")
	`TDHD_ASSERT_NOW(a_no_pop_blocked, out_vld_q && !m_tready, !pop, "character taken while result blocked")

endmodule

`default_nettype wire

@@ sv/two_digit_hex_dec_id_parser_top.sv @@
// Two-digit hex/decimal ID parser: one character per cycle in unless the output stalls,
// one result per token out. A terminator passes the front stage register and the queue,
// then the back end loads its result into the result register that drives m_tvalid.
// A stalled output holds the back end; the two-entry queue and front stage absorb 3 more.
// Reset (arst_n low, asynchronous): preset auto, parser cleared, queue and result empty.
// Depends on tdhd_pkg, tdhd_front, tdhd_queue and tdhd_back.
`default_nettype none

module two_digit_hex_dec_id_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_wdata,  // preset_format
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,    // [7:0] character
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata     // [3:0] status, [11:4] id_value, [12] id_valid,
	                                     // [13] saw_hex, [14] saw_dec, [15] zero
);
	import tdhd_pkg::*;

	logic [1:0]  preset_format_q;
	logic        push, q_full, pop, q_valid;
	class_t      push_cls, head;

	// Preset format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_format_q <= PRE_AUTO;
		end else if (cfg_we) begin
			preset_format_q <= cfg_wdata;
		end
	end

	tdhd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.push     (push),
		.push_cls (push_cls),
		.q_full   (q_full)
	);

	tdhd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cls (push_cls),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.head     (head)
	);

	tdhd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.preset_format (preset_format_q),
		.q_valid       (q_valid),
		.head          (head),
		.pop           (pop),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata)
	);

endmodule

`default_nettype wire

@@ verif/tdhd_id_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the two-digit hex/decimal ID parser: watches the register port and both
// streams, predicts each token's result and compares it with the output transfer.
// Depends on tdhd_pkg for the status codes, preset codes and MAX_LEN.

module tdhd_id_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,    // [7:0] character
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,    // [3:0] status, [11:4] id_value, [12] id_valid,
	                                     // [13] saw_hex, [14] saw_dec, [15] zero
	output int               pending,
	output int               errors
);
	import tdhd_pkg::*;

	localparam logic [4:0] NIB_NONE = 5'h10;

	typedef enum logic [3:0] {
		P_INIT, P_ZERO1, P_PREFIX, P_IND1, P_IND2, P_DEC1, P_DEC2, P_HEX1,
		P_HEX2, P_ZERO2, P_DONE, P_PHEX, P_PDEC, P_PDEC_Z1, P_PDEC_Z2
	} parse_state_t;

	typedef struct {
		stat_t      status;
		logic [7:0] id_value;
		logic       id_valid;
		logic       saw_hex;
		logic       saw_dec;
	} id_result_t;

	// Predicted parser state
	logic [1:0]   preset;
	parse_state_t pst;
	logic         skipping;
	logic [4:0]   char_cnt;
	logic [4:0]   nib_hi;
	logic [4:0]   nib_lo;
	logic         hex_seen;
	logic         dec_seen;
	logic         prefix_seen;
	stat_t        err_code;
	logic         halted;

	id_result_t expected_ids[$];
	id_result_t got_id;
	id_result_t new_id;
	logic       token_ended;
	int         err_total;

	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 5'(c - "0");
		if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
		if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
		return NIB_NONE;
	endfunction

	function automatic int check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	task automatic clear_token();
		pst = P_INIT;
		skipping = 1'b1;
		char_cnt = '0;
		nib_hi = NIB_NONE;
		nib_lo = NIB_NONE;
		hex_seen = 1'b0;
		dec_seen = 1'b0;
		prefix_seen = 1'b0;
		err_code = ST_GOOD;
		halted = 1'b0;
	endtask

	task automatic halt_with(input stat_t code);
		err_code = code;
		halted = 1'b1;
	endtask

	// One step of the digit/prefix/suffix state machine
	task automatic parse_step(input logic [7:0] c);
		logic [4:0] n;
		logic isx, isdig, xch, hch, dch;
		n = nibble_of(c);
		isx = (n != NIB_NONE);
		isdig = (c >= "0" && c <= "9");
		xch = (c == "x" || c == "X");
		hch = (c == "h" || c == "H");
		dch = (c == "d" || c == "D");
		case (pst)
			P_INIT: begin
				if (c == "0") begin
					nib_hi = 5'd0;
					pst = P_ZERO1;
				end else if (isx) begin
					if (isdig) begin
						pst = P_IND1;
					end else begin
						hex_seen = 1'b1;
						pst = P_HEX1;
					end
					nib_hi = n;
				end else if (xch) begin
					hex_seen = 1'b1;
					prefix_seen = 1'b1;
					pst = P_PREFIX;
				end else begin
					halt_with(ST_BAD_FIRST);
				end
			end
			P_ZERO1: begin
				if (c == "0") begin
					nib_lo = 5'd0;
					pst = P_ZERO2;
				end else if (xch) begin
					hex_seen = 1'b1;
					prefix_seen = 1'b1;
					pst = P_PREFIX;
				end else if (isx) begin
					if (!isdig) begin
						hex_seen = 1'b1;
						pst = P_HEX2;
					end else begin
						pst = P_IND2;
					end
					nib_hi = n;
				end else if (hch) begin
					hex_seen = 1'b1;
					pst = P_DONE;
				end else begin
					halt_with(ST_BAD_DIG2);
				end
			end
			P_PREFIX: begin
				if (isx) begin
					nib_hi = n;
					pst = P_HEX1;
				end else begin
					halt_with(ST_BAD_DIG1);
				end
			end
			P_IND1: begin
				if (isx) begin
					if (isdig) begin
						pst = P_IND2;
					end else begin
						hex_seen = 1'b1;
						pst = P_HEX2;
					end
					nib_lo = n;
				end else if (xch || hch) begin
					hex_seen = 1'b1;
					pst = P_DONE;
				end else begin
					halt_with(ST_BAD_DIG2);
				end
			end
			P_IND2: begin
				if (xch || hch) begin
					hex_seen = 1'b1;
					pst = P_DONE;
				end else if (dch) begin
					dec_seen = 1'b1;
					pst = P_DONE;
				end else begin
					halt_with(ST_TOO_MANY);
				end
			end
			P_DEC1: begin
				if (isdig) begin
					nib_lo = n;
					pst = P_DEC2;
				end else begin
					halt_with(ST_BAD_DIG2);
				end
			end
			P_DEC2, P_PDEC_Z2: begin
				if (dch) pst = P_DONE;
				else halt_with(ST_BAD_SUFFIX);
			end
			P_HEX1: begin
				if (isx) begin
					nib_lo = n;
					pst = P_HEX2;
				end else if (xch || hch) begin
					if (prefix_seen) begin
						halt_with(ST_PRE_AND_SUF);
					end else begin
						hex_seen = 1'b1;
						pst = P_DONE;
					end
				end else begin
					halt_with(ST_BAD_DIG2);
				end
			end
			P_HEX2: begin
				if (xch || hch) pst = P_DONE;
				else halt_with(ST_BAD_SUFFIX);
			end
			P_ZERO2: begin
				if (!dec_seen && (xch || hch)) begin
					hex_seen = 1'b1;
					pst = P_DONE;
				end else if (!hex_seen && dch) begin
					dec_seen = 1'b1;
					pst = P_DONE;
				end else begin
					halt_with(ST_TOO_MANY);
				end
			end
			P_PHEX: begin
				if (xch) begin
					prefix_seen = 1'b1;
					pst = P_PREFIX;
				end else if (c == "0") begin
					nib_hi = 5'd0;
					pst = P_ZERO1;
				end else if (isx) begin
					nib_hi = n;
					pst = P_HEX1;
				end else begin
					halt_with(ST_BAD_FIRST);
				end
			end
			P_PDEC: begin
				if (xch || (isx && !isdig)) begin
					halt_with(ST_HEX_DEC1);
				end else if (c == "0") begin
					nib_hi = 5'd0;
					pst = P_PDEC_Z1;
				end else if (isdig) begin
					nib_hi = n;
					pst = P_DEC1;
				end else begin
					halt_with(ST_BAD_FIRST);
				end
			end
			P_PDEC_Z1: begin
				if (xch || (isx && !isdig)) begin
					halt_with(ST_HEX_DEC2);
				end else if (c == "0") begin
					pst = P_PDEC_Z2;
				end else if (isdig) begin
					nib_hi = n;
					pst = P_DEC2;
				end else begin
					halt_with(ST_BAD_SECOND);
				end
			end
			default: halt_with(ST_TOO_MANY);
		endcase
	endtask

	// Pick up the preset and the start state on the first character past the blanks
	task automatic enter_parser();
		skipping = 1'b0;
		char_cnt = '0;
		hex_seen = (preset == PRE_HEX);
		dec_seen = (preset == PRE_DEC);
		if (hex_seen) pst = P_PHEX;
		else if (dec_seen) pst = P_PDEC;
		else pst = P_INIT;
	endtask

	// Advance the prediction by one character; a terminator yields a result
	task automatic take_character(input logic [7:0] c, output logic ended, output id_result_t r);
		logic [3:0] fn, msd, lsd;
		ended = 1'b0;
		r.status = ST_GOOD;
		r.id_value = '0;
		r.id_valid = 1'b0;
		r.saw_hex = 1'b0;
		r.saw_dec = 1'b0;
		if (c != 8'h00) begin
			if (skipping && char_cnt <= 2 * MAX_LEN && (c == " " || c == "\t")) begin
				char_cnt++;
			end else begin
				if (skipping) enter_parser();
				if (!halted && char_cnt <= MAX_LEN) begin
					parse_step(c);
					if (!halted) char_cnt++;
				end
			end
		end else begin
			ended = 1'b1;
			if (skipping) begin
				r.status = ST_BLANK_ONLY;
				hex_seen = (preset == PRE_HEX);
				dec_seen = (preset == PRE_DEC);
			end else if (char_cnt >= MAX_LEN) begin
				r.status = ST_TOO_MANY;
			end else if (halted) begin
				r.status = err_code;
			end else if ((hex_seen || dec_seen) && nib_hi == NIB_NONE && nib_lo == NIB_NONE) begin
				r.status = ST_NO_DIGITS;
			end else begin
				// An absent digit counts as zero
				fn = (nib_hi == NIB_NONE) ? 4'd0 : nib_hi[3:0];
				if (nib_lo == NIB_NONE) begin
					msd = 4'd0;
					lsd = fn;
				end else begin
					msd = fn;
					lsd = nib_lo[3:0];
				end
				if (hex_seen || !dec_seen) r.id_value = 8'(msd) * 8'd16 + 8'(lsd);
				else r.id_value = 8'(msd) * 8'd10 + 8'(lsd);
			end
			r.id_valid = (r.status == ST_GOOD);
			r.saw_hex = hex_seen;
			r.saw_dec = dec_seen;
			clear_token();
		end
	endtask

	// Compare output transfers first, then absorb register writes and input transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset = PRE_AUTO;
			clear_token();
			expected_ids.delete();
			err_total = 0;
			pending <= 0;
			errors <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_ids.size() == 0) begin
					$error("result transfer with no token outstanding: m_tdata %h", m_tdata);
					err_total++;
				end else begin
					got_id = expected_ids.pop_front();
					err_total += check_field("status", got_id.status, m_tdata[3:0]);
					err_total += check_field("id_value", got_id.id_value, m_tdata[11:4]);
					err_total += check_field("id_valid", got_id.id_valid, m_tdata[12]);
					err_total += check_field("saw_hex", got_id.saw_hex, m_tdata[13]);
					err_total += check_field("saw_dec", got_id.saw_dec, m_tdata[14]);
				end
			end
			if (cfg_we) preset = cfg_wdata;
			if (s_tvalid && s_tready) begin
				take_character(s_tdata, token_ended, new_id);
				if (token_ended) expected_ids.push_back(new_id);
			end
			pending <= expected_ids.size();
			errors <= err_total;
		end
	end

endmodule

@@ verif/tb_two_digit_hex_dec_id_parser_top.sv @@
`timescale 1ns / 100ps
// Top of the ID parser testbench: clock, reset, token stimulus, preset writes and verdict.
// Depends on tdhd_pkg, the parser top level and tdhd_id_checker.

module tb_two_digit_hex_dec_id_parser_top;
	import tdhd_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;     // [7:0] character
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // [3:0] status, [11:4] id_value, [12] id_valid,
	                               // [13] saw_hex, [14] saw_dec, [15] zero
	int          pending;
	int          errors;

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          chars_sent = 0;
	logic [7:0]  token_q[$];

	two_digit_hex_dec_id_parser_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	tdhd_id_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.pending   (pending),
		.errors    (errors)
	);

	always #5 clk = ~clk;

	// Stall the result stream at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Bound the run
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Offer one character, idling first at random, and hold until the transfer
	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_string(input string s);
		int i;
		for (i = 0; i < s.len(); i++) send_char(s[i]);
		send_char(8'h00);
	endtask

	// Drop valid and wait until every token's result has been taken
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_preset(input logic [1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10) return 8'h30 + 8'(n);
		if ($urandom_range(1)) return 8'h61 + 8'(n) - 8'd10;
		return 8'h41 + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] suffix_char();
		case ($urandom_range(3))
			0: return "h";
			1: return "H";
			2: return "x";
			default: return "X";
		endcase
	endfunction

	// Characters the parser treats specially, plus the odd printable one
	function automatic logic [7:0] telling_char();
		case ($urandom_range(11))
			0: return hex_char(4'($urandom_range(9)));
			1: return hex_char(4'($urandom_range(15, 10)));
			2: return "x";
			3: return "X";
			4: return "h";
			5: return "H";
			6: return "d";
			7: return "D";
			8: return " ";
			9: return "\t";
			10: return "0";
			default: return 8'($urandom_range(33, 126));
		endcase
	endfunction

	// Assemble one token: mostly well-formed values, some malformed and some noise
	task automatic build_token();
		int k;
		int nblank;
		token_q.delete();
		k = $urandom_range(99);
		nblank = (k < 70) ? 0 : (k < 90) ? $urandom_range(1, 3) : $urandom_range(9, 12);
		repeat (nblank) token_q.push_back($urandom_range(1) ? 8'h20 : 8'h09);
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: begin token_q.push_back("0"); token_q.push_back("x"); end
					1: begin token_q.push_back("0"); token_q.push_back("X"); end
					2: token_q.push_back("x");
					default: token_q.push_back("X");
				endcase
				repeat ($urandom_range(1, 2)) token_q.push_back(hex_char(4'($urandom)));
			end
			1: begin
				repeat ($urandom_range(1, 2)) token_q.push_back(hex_char(4'($urandom)));
				token_q.push_back(suffix_char());
			end
			2: begin
				repeat ($urandom_range(1, 2)) token_q.push_back(8'h30 + 8'($urandom_range(9)));
				if ($urandom_range(1)) token_q.push_back($urandom_range(1) ? "d" : "D");
			end
			3: begin
				token_q.push_back("0");
				if ($urandom_range(1)) token_q.push_back("0");
				case ($urandom_range(3))
					0: token_q.push_back("d");
					1: token_q.push_back("h");
					2: token_q.push_back("x");
					default: ;
				endcase
			end
			4: begin
				token_q.push_back("0");
				token_q.push_back("x");
				repeat ($urandom_range(1, 2)) token_q.push_back(hex_char(4'($urandom)));
				token_q.push_back(suffix_char());
			end
			5: repeat ($urandom_range(1, 4)) token_q.push_back(telling_char());
			6: repeat ($urandom_range(1, 7)) token_q.push_back(8'($urandom_range(1, 255)));
			7: repeat ($urandom_range(5, 8)) token_q.push_back(hex_char(4'($urandom)));
			8: repeat ($urandom_range(1, 2)) token_q.push_back(hex_char(4'($urandom)));
			default: ;
		endcase
		if ($urandom_range(19) == 0) token_q.push_back(telling_char());
		token_q.push_back(8'h00);
	endtask

	task automatic run_phase(input int idle_pct, input int stall, input int n_chars);
		int stop_at;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		stop_at = chars_sent + n_chars;
		write_preset(2'($urandom_range(3)));
		while (chars_sent < stop_at) begin
			if ($urandom_range(29) == 0) write_preset(2'($urandom_range(3)));
			build_token();
			while (token_q.size() != 0) send_char(token_q.pop_front());
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed tokens: prefix, suffixes, extremes, empty token and every preset
		write_preset(PRE_AUTO);
		send_string("0x1F");
		send_string("FFh");
		send_string("99d");
		send_char(8'hFF);
		send_char(8'h00);
		send_string("");
		write_preset(PRE_HEX);
		send_string("0");
		write_preset(PRE_DEC);
		send_string("x");
		write_preset(2'd3);
		send_string("01");

		// Random tokens under each idling pattern
		run_phase(0, 0, 175);
		run_phase(69, 0, 175);
		run_phase(0, 69, 175);
		run_phase(28, 28, 175);

		settle();
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
